### rtl/mvfv_pkg.sv
// Package: shared types, constants and helper functions for the MAVLink v1 frame validator.
`timescale 1ns / 1ps

package mvfv_pkg;

  localparam logic [7:0] START_MARK  = 8'hFE;
  localparam logic [15:0] CRC_SEED   = 16'hFFFF;
  localparam logic [8:0] POS_MAX     = 9'd511;
  localparam logic [8:0] MIN_FRAME   = 9'd8;
  localparam logic [8:0] HDR_LAST    = 9'd5;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_ID = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_ON = 1'd1;

  typedef enum logic [2:0] {
    ST_VALID        = 3'd0,
    ST_BAD_LENGTH   = 3'd1,
    ST_UNKNOWN_ID   = 3'd2,
    ST_BAD_CRC      = 3'd3,
    ST_BAD_SOURCE   = 3'd4,
    ST_BAD_SEQUENCE = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] src_id;
    logic       seq_on;
  } cfg_t;

  // One queue entry: either a clear command or a fully assembled frame summary.
  typedef struct packed {
    logic        is_clear;
    logic        len_bad;
    logic [7:0]  seq;
    logic [7:0]  sys;
    logic [7:0]  comp;
    logic [7:0]  id;
    logic [7:0]  len;
    logic [15:0] crc;
    logic [15:0] trailer;
  } q_entry_t;

  // One byte of X.25 / MCRF4XX CRC.
  function automatic logic [15:0] crc_step(input logic [7:0] b, input logic [15:0] crc);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ {t[3:0], 4'b0};
    return {8'b0, crc[15:8]} ^ {t, 8'b0} ^ {5'b0, t, 3'b0} ^ {12'b0, t[7:4]};
  endfunction

  // Returns {known, extra byte} for a message id.
  function automatic logic [8:0] extra_lookup(input logic [7:0] id);
    logic [8:0] r;
    case (id)
      8'd0:    r = {1'b1, 8'd50};
      8'd1:    r = {1'b1, 8'd124};
      8'd24:   r = {1'b1, 8'd24};
      8'd30:   r = {1'b1, 8'd39};
      8'd33:   r = {1'b1, 8'd104};
      8'd74:   r = {1'b1, 8'd20};
      8'd76:   r = {1'b1, 8'd152};
      8'd77:   r = {1'b1, 8'd143};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/mvfv_in_if.sv
// Interface: input byte channel (valid/ready handshake).
`timescale 1ns / 1ps

interface mvfv_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] byte_value;
  logic       frame_end;

  modport source (output valid, command, byte_value, frame_end, input ready);
  modport sink   (input valid, command, byte_value, frame_end, output ready);
endinterface

### rtl/mvfv_out_if.sv
// Interface: result channel (valid/ready handshake).
`timescale 1ns / 1ps

interface mvfv_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] frame_sequence;
  logic [7:0] source_system;
  logic [7:0] source_component;
  logic [7:0] message_kind;
  logic [7:0] payload_length;
  logic [7:0] last_good_sequence;

  modport source (output valid, status, frame_sequence, source_system, source_component,
                  message_kind, payload_length, last_good_sequence, input ready);
  modport sink   (input valid, status, frame_sequence, source_system, source_component,
                  message_kind, payload_length, last_good_sequence, output ready);
endinterface

### rtl/mvfv_front.sv
// Front end: assembles frame bytes, runs the CRC, emits one queue entry per frame or clear.
`timescale 1ns / 1ps

module mvfv_front
  import mvfv_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  mvfv_in_if.sink  in_ch,
  input  logic     q_full,
  output logic     q_push,
  output q_entry_t q_data
);

  logic [8:0]  pos_r, pos_nxt;
  logic        start_r, start_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [31:0] hdr_r, hdr_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] trl_r, trl_nxt;
  logic        acc;

  assign in_ch.ready = !q_full;
  assign acc = in_ch.valid && !q_full;

  always_comb begin
    pos_nxt   = pos_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    hdr_nxt   = hdr_r;
    crc_nxt   = crc_r;
    trl_nxt   = trl_r;
    q_push    = 1'b0;
    q_data    = '0;
    if (acc) begin
      if (in_ch.command) begin
        q_push        = 1'b1;
        q_data.is_clear = 1'b1;
      end else begin
        case (pos_r)
          9'd0:    start_nxt = (in_ch.byte_value == START_MARK);
          9'd1:    len_nxt = in_ch.byte_value;
          9'd2:    hdr_nxt[7:0] = in_ch.byte_value;
          9'd3:    hdr_nxt[15:8] = in_ch.byte_value;
          9'd4:    hdr_nxt[23:16] = in_ch.byte_value;
          9'd5:    hdr_nxt[31:24] = in_ch.byte_value;
          default: ;
        endcase
        // CRC covers bytes 1 .. 5+length
        if (pos_r != 9'd0 && (pos_r <= HDR_LAST || pos_r <= HDR_LAST + {1'b0, len_r})) begin
          crc_nxt = crc_step(in_ch.byte_value, crc_r);
        end
        trl_nxt = {in_ch.byte_value, trl_r[15:8]};
        pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + 9'd1;
        if (in_ch.frame_end) begin
          q_push          = 1'b1;
          q_data.is_clear = 1'b0;
          q_data.len_bad  = (pos_nxt < MIN_FRAME) || !start_nxt ||
                            (pos_nxt != MIN_FRAME + {1'b0, len_nxt});
          q_data.seq      = hdr_nxt[7:0];
          q_data.sys      = hdr_nxt[15:8];
          q_data.comp     = hdr_nxt[23:16];
          q_data.id       = hdr_nxt[31:24];
          q_data.len      = len_nxt;
          q_data.crc      = crc_nxt;
          q_data.trailer  = trl_nxt;
          pos_nxt   = '0;
          start_nxt = 1'b0;
          len_nxt   = '0;
          hdr_nxt   = '0;
          crc_nxt   = CRC_SEED;
          trl_nxt   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      start_r <= 1'b0;
      len_r   <= '0;
      hdr_r   <= '0;
      crc_r   <= CRC_SEED;
      trl_r   <= '0;
    end else begin
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      hdr_r   <= hdr_nxt;
      crc_r   <= crc_nxt;
      trl_r   <= trl_nxt;
    end
  end

endmodule

### rtl/mvfv_queue.sv
// Small FIFO of frame summaries and clear commands between front end and checker.
`timescale 1ns / 1ps

module mvfv_queue
  import mvfv_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_data,
  input  logic     pop,
  output q_entry_t head,
  output logic     head_valid,
  output logic     full
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  q_entry_t        mem_r [DEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rp_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### rtl/mvfv_back.sv
// Back end: final CRC byte, priority checks, sequence history and the output register.
`timescale 1ns / 1ps

module mvfv_back
  import mvfv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  q_entry_t  head,
  input  logic      head_valid,
  output logic      pop,
  mvfv_out_if.source out_ch
);

  logic       out_valid_r;
  status_t    status_r;
  logic [7:0] seq_r, sys_r, comp_r, id_r, len_r, last_r;
  logic [7:0] prev_r, prev_nxt;
  logic       have_r, have_nxt;
  logic [8:0] lk;
  status_t    status_c;
  logic       load;

  assign lk = extra_lookup(head.id);

  always_comb begin
    if (head.len_bad) begin
      status_c = ST_BAD_LENGTH;
    end else if (!lk[8]) begin
      status_c = ST_UNKNOWN_ID;
    end else if (crc_step(lk[7:0], head.crc) != head.trailer) begin
      status_c = ST_BAD_CRC;
    end else if (cfg.src_id != 8'd0 && head.sys != cfg.src_id) begin
      status_c = ST_BAD_SOURCE;
    end else if (cfg.seq_on && have_r && head.seq != prev_r + 8'd1) begin
      status_c = ST_BAD_SEQUENCE;
    end else begin
      status_c = ST_VALID;
    end
  end

  // clears never wait on the output register
  assign pop  = head_valid && (head.is_clear || !out_valid_r || out_ch.ready);
  assign load = pop && !head.is_clear;

  always_comb begin
    prev_nxt = prev_r;
    have_nxt = have_r;
    if (pop) begin
      if (head.is_clear) begin
        prev_nxt = '0;
        have_nxt = 1'b0;
      end else if (status_c == ST_VALID && cfg.seq_on) begin
        prev_nxt = head.seq;
        have_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      prev_r      <= '0;
      have_r      <= 1'b0;
    end else begin
      prev_r <= prev_nxt;
      have_r <= have_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= status_c;
      seq_r    <= head.seq;
      sys_r    <= head.sys;
      comp_r   <= head.comp;
      id_r     <= head.id;
      len_r    <= head.len;
      last_r   <= prev_nxt;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.status             = status_r;
  assign out_ch.frame_sequence     = seq_r;
  assign out_ch.source_system      = sys_r;
  assign out_ch.source_component   = comp_r;
  assign out_ch.message_kind       = id_r;
  assign out_ch.payload_length     = len_r;
  assign out_ch.last_good_sequence = last_r;

endmodule

### rtl/mavlink_v1_frame_validator_top.sv
// Top level: MAVLink v1 frame validator with configuration registers.
`timescale 1ns / 1ps

// Usage
//  in_ch  : one item per byte. command=0 carries byte_value, frame_end marks
//           the last byte of a frame. command=1 clears sequence history and
//           produces no result.
//  out_ch : one result per frame, status plus the header fields and the
//           stored sequence after the check.
//  cfg_*  : write port, index 0 = expected source id (0 = any), index 1 =
//           sequence check enable. Write only while no frame is in flight.
// Timing
//  One byte per cycle sustained while the queue is not full; the CRC is updated
//  one byte per cycle in the front end. A result is written to the queue at the
//  edge that accepts its last byte and then loaded into the checker's output
//  register. The checker finishes one frame per cycle, limited by its output
//  register: it loads only while that register is empty or out_ch.ready is high.
// Stall / reset
//  A stalled receiver holds the result; the queue (QUEUE_DEPTH entries) keeps
//  taking frames, and in_ch.ready drops only when the queue is full.
//  Synchronous reset clears frame assembly, queue, sequence history and the
//  configuration registers; no clearing pass is needed.
module mavlink_v1_frame_validator_top
  import mvfv_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mvfv_in_if.sink               in_ch,
  mvfv_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t     cfg_r;
  q_entry_t push_data, head;
  logic     push, pop, head_valid, q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SRC_ID: cfg_r.src_id <= cfg_data;
        CFG_SEQ_ON: cfg_r.seq_on <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  mvfv_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (push),
    .q_data (push_data)
  );

  mvfv_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (q_full)
  );

  mvfv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

### rtl/mvfv_checker.sv
// Checker: port-level assertions for the frame validator, bound to the top level.
`timescale 1ns / 1ps

module mvfv_checker
  import mvfv_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic [7:0] frame_sequence,
  input logic [7:0] message_kind,
  input logic [7:0] last_good_sequence
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(frame_sequence) && $stable(last_good_sequence))
    else $error("stalled result changed");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> status <= ST_BAD_SEQUENCE)
    else $error("status code out of range");

  a_known_id: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && status != ST_BAD_LENGTH && status != ST_UNKNOWN_ID
      |-> extra_lookup(message_kind) >= 9'h100)
    else $error("id past lookup is not in table");

  a_bad_seq: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && status == ST_BAD_SEQUENCE
      |-> frame_sequence != last_good_sequence + 8'd1)
    else $error("bad sequence reported for a following sequence");

endmodule

bind mavlink_v1_frame_validator_top mvfv_checker u_mvfv_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .status             (out_ch.status),
  .frame_sequence     (out_ch.frame_sequence),
  .message_kind       (out_ch.message_kind),
  .last_good_sequence (out_ch.last_good_sequence)
);
